/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/core/pil_pkg.sv */
// ----------------------------------------------------------------------------
// pil_pkg
// Types and constants for the positional insert/remove list.
// ----------------------------------------------------------------------------
package pil_pkg;

    localparam int DEPTH       = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = 7;
    localparam int VAL_IN_W    = 32;
    localparam int RV_W        = 32;
    localparam int LEN_W       = 7;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_ZERO  = 2'd3
    } status_t;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INS,
        S_REM_TAKE,
        S_REM
    } state_t;

    typedef struct packed {
        logic                action;
        logic                at_end;
        logic [POS_W-1:0]    position;
        logic [VAL_IN_W-1:0] value;
    } pil_req_t;

    typedef struct packed {
        logic [RV_W-1:0]  removed_value;
        logic [LEN_W-1:0] length;
        status_t          status;
    } pil_res_t;

endpackage

/* rtl/core/pil_ram.sv */
// ----------------------------------------------------------------------------
// pil_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pil_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/positional_insert_remove_list.sv */
// ----------------------------------------------------------------------------
// positional_insert_remove_list
// Ordered list of nonzero words with positional insert and remove.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and cannot be held
// off. A rejected item (zero value, full store, position past the end) gives
// its result in the cycle after it is taken and changes nothing. An accepted
// insert keeps busy high while the entries from its position on are shifted
// up and the value is written, and an accepted remove while the removed entry
// is read and the entries after it are shifted down. The entry store is a
// single RAM with one read and one write port: the shift streams one entry per
// cycle, each written back in the cycle after it is read. The next item may be
// taken in the cycle its result is shown.
`include "assert_macros.svh"

module positional_insert_remove_list
    import pil_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  pil_req_t request,
    output logic     done,
    output pil_res_t result
);

    state_t                 state_reg,  state_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [CNT_W-1:0]       ptr_reg,    ptr_next;
    logic [CNT_W-1:0]       tgt_reg,    tgt_next;
    logic [ADDR_W-1:0]      wptr_reg,   wptr_next;
    logic                   pend_reg,   pend_next;
    logic                   take_reg,   take_next;
    logic [VALUE_WIDTH-1:0] val_reg,    val_next;
    logic [VALUE_WIDTH-1:0] taken_reg,  taken_next;
    logic                   done_reg,   done_next;
    pil_res_t               res_reg,    res_next;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic                   ram_re;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [VALUE_WIDTH-1:0] ram_rdata;

    logic                   accept;
    logic [CNT_W-1:0]       in_tgt;
    logic [VALUE_WIDTH-1:0] in_val;
    status_t                in_status;
    logic                   ins_done;
    logic                   rem_done;

    logic                   ram_clash;
    logic                   reject_shown;

    pil_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = res_reg;

    // Request checks, in the order zero value, full store, range; a remove is checked for range only.
    always_comb
    begin
        in_tgt    = request.at_end ? count_reg : CNT_W'(request.position);
        in_val    = request.value[VALUE_WIDTH-1:0];
        in_status = ST_OK;
        if (request.action == ACT_INSERT)
        begin
            if (in_val == '0)
                in_status = ST_ZERO;
            else if (count_reg == CNT_W'(DEPTH))
                in_status = ST_FULL;
            else if (in_tgt > count_reg)
                in_status = ST_RANGE;
        end
        else
        begin
            if (in_tgt >= count_reg)
                in_status = ST_RANGE;
        end
    end

    assign ins_done = (ptr_reg == tgt_reg) && !pend_reg;
    assign rem_done = !take_reg && !pend_reg && !(ptr_reg < count_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && in_status == ST_OK)
                    state_next = (request.action == ACT_REMOVE) ? S_REM_TAKE : S_INS;
            end
            S_INS:
            begin
                if (ins_done)
                    state_next = S_IDLE;
            end
            S_REM_TAKE:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                if (rem_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and RAM control. Writes follow their reads in the next cycle
    // and move away from the read address, so a cycle never reads and writes
    // the same entry.
    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        tgt_next   = tgt_reg;
        wptr_next  = wptr_reg;
        pend_next  = 1'b0;
        take_next  = 1'b0;
        val_next   = val_reg;
        taken_next = taken_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = wptr_reg;
        ram_wdata  = ram_rdata;
        ram_re     = 1'b0;
        ram_raddr  = ptr_reg[ADDR_W-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    tgt_next = in_tgt;
                    val_next = in_val;
                    ptr_next = (request.action == ACT_REMOVE) ? in_tgt : count_reg;
                    if (in_status != ST_OK)
                    begin
                        done_next              = 1'b1;
                        res_next.removed_value = '0;
                        res_next.length        = LEN_W'(count_reg);
                        res_next.status        = in_status;
                    end
                end
            end
            S_INS:
            begin
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (ptr_reg != tgt_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = ADDR_W'(ptr_reg - 1'b1);
                    pend_next = 1'b1;
                    wptr_next = ptr_reg[ADDR_W-1:0];
                    ptr_next  = ptr_reg - 1'b1;
                end
                else if (!pend_reg)
                begin
                    ram_we                 = 1'b1;
                    ram_waddr              = tgt_reg[ADDR_W-1:0];
                    ram_wdata              = val_reg;
                    count_next             = count_reg + 1'b1;
                    done_next              = 1'b1;
                    res_next.removed_value = '0;
                    res_next.length        = LEN_W'(count_reg + 1'b1);
                    res_next.status        = ST_OK;
                end
            end
            S_REM_TAKE:
            begin
                ram_re    = 1'b1;
                ptr_next  = ptr_reg + 1'b1;
                take_next = 1'b1;
            end
            S_REM:
            begin
                if (take_reg)
                begin
                    taken_next = ram_rdata;
                end
                if (pend_reg)
                begin
                    ram_we = 1'b1;
                end
                if (ptr_reg < count_reg)
                begin
                    ram_re    = 1'b1;
                    pend_next = 1'b1;
                    wptr_next = ADDR_W'(ptr_reg - 1'b1);
                    ptr_next  = ptr_reg + 1'b1;
                end
                else if (rem_done)
                begin
                    count_next             = count_reg - 1'b1;
                    done_next              = 1'b1;
                    res_next.removed_value = RV_W'(taken_reg);
                    res_next.length        = LEN_W'(count_reg - 1'b1);
                    res_next.status        = ST_OK;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            take_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            take_reg  <= take_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        tgt_reg   <= tgt_next;
        wptr_reg  <= wptr_next;
        val_reg   <= val_next;
        taken_reg <= taken_next;
        res_reg   <= res_next;
    end

    assign ram_clash    = ram_we && ram_re && (ram_waddr == ram_raddr);
    assign reject_shown = done && (result.status != ST_OK);

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(DEPTH), "count above depth")
    `ASSERT_ALWAYS(a_no_rw_clash, clk, rst_n, !ram_clash, "read and write hit one entry")
    `ASSERT_IMPLIES(a_reject_keeps, clk, rst_n, reject_shown, $stable(count_reg), "count moved")
    `ASSERT_IMPLIES(a_end_reports, clk, rst_n, $fell(busy), done, "busy fell without a result")

endmodule
